@@ hw/rtl/sorted_record_table_search_macros.svh @@
`ifndef SORTED_RECORD_TABLE_SEARCH_MACROS_SVH
`define SORTED_RECORD_TABLE_SEARCH_MACROS_SVH

// same-cycle implication, checked out of reset
`define SRTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srts: same-cycle check failed");

// next-cycle implication, checked out of reset
`define SRTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srts: next-cycle check failed");

`endif

@@ hw/rtl/srts_pkg.sv @@
`timescale 1ns / 1ps

package srts_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATE_W   = 27;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned POS_W    = 10;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } srts_op_e;

  typedef enum logic [1:0] {
    RES_INSERTED  = 2'd0,
    RES_FOUND     = 2'd1,
    RES_NOT_FOUND = 2'd2,
    RES_FULL      = 2'd3
  } srts_status_e;

  typedef enum logic [1:0] {
    RD_COUNT_M1 = 2'd0,
    RD_J_M2     = 2'd1,
    RD_MID      = 2'd2
  } srts_rdsel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_PLACE,
    S_LK_PROBE,
    S_LK_CMP,
    S_RESP
  } srts_state_e;

  typedef struct packed {
    logic [DATE_W-1:0] date;
    logic [WORD_W-1:0] temperature;
    logic [WORD_W-1:0] phosphate;
    logic [WORD_W-1:0] silicate;
    logic [WORD_W-1:0] nitrite;
    logic [WORD_W-1:0] nitrate;
    logic [WORD_W-1:0] salinity;
    logic [WORD_W-1:0] oxygen;
  } srts_rec_t;

  typedef struct packed {
    logic         accept;
    logic         j_init;
    logic         j_dec;
    logic         rd_en;
    srts_rdsel_e  rd_sel;
    logic         shift_we;
    logic         place_we;
    logic         lk_init;
    logic         m_load;
    logic         lo_up;
    logic         hi_dn;
    logic         status_we;
    srts_status_e status;
    logic         out_load;
  } srts_cmd_t;

  typedef struct packed {
    logic count_full;
    logic count_zero;
    logic j_one;
    logic rd_gt;
    logic rd_eq;
    logic range_empty;
    logic out_free;
  } srts_sts_t;

endpackage

@@ hw/rtl/sorted_record_table_search.sv @@
`timescale 1ns / 1ps

// Sorted record table with insert and binary-search lookup.
// Input channel: in_valid_i / in_stall_o with op_i, record_date_i and seven
// payload words; op 0 inserts a record, op 1 looks up a date.
// Output channel: out_valid_o / out_stall_i with status_o, position_o and
// seven payload words; exactly one result per input transfer.
// One item is worked at a time; in_stall_o is low only while idle, so the
// next input may transfer while the previous result still waits.
// Insert: each stored entry with a greater key (up to 1023 of them) is
// shifted up by one, then the record is placed in the gap; each shift
// moves one entry per cycle through the record memory.
// Lookup: binary search; each probe loads the midpoint in S_LK_PROBE and compares it in S_LK_CMP.
// A full table drops the insert and returns status 3.
// Reset clears the record count and the output valid; memory contents are
// not cleared and need no clearing pass.
// A stalled result holds in the output register until the transfer; the
// controller waits for it before loading the next result.

module sorted_record_table_search (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [srts_pkg::DATE_W-1:0] record_date_i,
  input  logic [srts_pkg::WORD_W-1:0] temperature_bits_i,
  input  logic [srts_pkg::WORD_W-1:0] phosphate_bits_i,
  input  logic [srts_pkg::WORD_W-1:0] silicate_bits_i,
  input  logic [srts_pkg::WORD_W-1:0] nitrite_bits_i,
  input  logic [srts_pkg::WORD_W-1:0] nitrate_bits_i,
  input  logic [srts_pkg::WORD_W-1:0] salinity_bits_i,
  input  logic [srts_pkg::WORD_W-1:0] oxygen_bits_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [srts_pkg::POS_W-1:0]  position_o,
  output logic [srts_pkg::WORD_W-1:0] temperature_out_o,
  output logic [srts_pkg::WORD_W-1:0] phosphate_out_o,
  output logic [srts_pkg::WORD_W-1:0] silicate_out_o,
  output logic [srts_pkg::WORD_W-1:0] nitrite_out_o,
  output logic [srts_pkg::WORD_W-1:0] nitrate_out_o,
  output logic [srts_pkg::WORD_W-1:0] salinity_out_o,
  output logic [srts_pkg::WORD_W-1:0] oxygen_out_o
);

  srts_pkg::srts_cmd_t cmd;
  srts_pkg::srts_sts_t sts;

  srts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  srts_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .record_date_i      (record_date_i),
    .temperature_bits_i (temperature_bits_i),
    .phosphate_bits_i   (phosphate_bits_i),
    .silicate_bits_i    (silicate_bits_i),
    .nitrite_bits_i     (nitrite_bits_i),
    .nitrate_bits_i     (nitrate_bits_i),
    .salinity_bits_i    (salinity_bits_i),
    .oxygen_bits_i      (oxygen_bits_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .status_o           (status_o),
    .position_o         (position_o),
    .temperature_out_o  (temperature_out_o),
    .phosphate_out_o    (phosphate_out_o),
    .silicate_out_o     (silicate_out_o),
    .nitrite_out_o      (nitrite_out_o),
    .nitrate_out_o      (nitrate_out_o),
    .salinity_out_o     (salinity_out_o),
    .oxygen_out_o       (oxygen_out_o)
  );

endmodule

@@ hw/rtl/srts_ctrl.sv @@
`timescale 1ns / 1ps

module srts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                op_i,
  input  srts_pkg::srts_sts_t sts_i,
  output srts_pkg::srts_cmd_t cmd_o,
  output logic                in_stall_o
);

  srts_pkg::srts_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srts_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      srts_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (op_i == srts_pkg::OP_LOOKUP) begin
            cmd_o.lk_init = 1'b1;
            state_d       = srts_pkg::S_LK_PROBE;
          end else if (sts_i.count_full) begin
            cmd_o.status_we = 1'b1;
            cmd_o.status    = srts_pkg::RES_FULL;
            state_d         = srts_pkg::S_RESP;
          end else if (sts_i.count_zero) begin
            cmd_o.j_init = 1'b1;
            state_d      = srts_pkg::S_INS_PLACE;
          end else begin
            cmd_o.j_init = 1'b1;
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = srts_pkg::RD_COUNT_M1;
            state_d      = srts_pkg::S_INS_SCAN;
          end
        end
      end
      srts_pkg::S_INS_SCAN: begin
        if (sts_i.rd_gt) begin
          cmd_o.shift_we = 1'b1;
          cmd_o.j_dec    = 1'b1;
          if (sts_i.j_one) begin
            state_d = srts_pkg::S_INS_PLACE;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = srts_pkg::RD_J_M2;
          end
        end else begin
          cmd_o.place_we  = 1'b1;
          cmd_o.status_we = 1'b1;
          cmd_o.status    = srts_pkg::RES_INSERTED;
          state_d         = srts_pkg::S_RESP;
        end
      end
      srts_pkg::S_INS_PLACE: begin
        cmd_o.place_we  = 1'b1;
        cmd_o.status_we = 1'b1;
        cmd_o.status    = srts_pkg::RES_INSERTED;
        state_d         = srts_pkg::S_RESP;
      end
      srts_pkg::S_LK_PROBE: begin
        if (sts_i.range_empty) begin
          cmd_o.status_we = 1'b1;
          cmd_o.status    = srts_pkg::RES_NOT_FOUND;
          state_d         = srts_pkg::S_RESP;
        end else begin
          cmd_o.m_load = 1'b1;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = srts_pkg::RD_MID;
          state_d      = srts_pkg::S_LK_CMP;
        end
      end
      srts_pkg::S_LK_CMP: begin
        if (sts_i.rd_eq) begin
          cmd_o.status_we = 1'b1;
          cmd_o.status    = srts_pkg::RES_FOUND;
          state_d         = srts_pkg::S_RESP;
        end else if (sts_i.rd_gt) begin
          cmd_o.hi_dn = 1'b1;
          state_d     = srts_pkg::S_LK_PROBE;
        end else begin
          cmd_o.lo_up = 1'b1;
          state_d     = srts_pkg::S_LK_PROBE;
        end
      end
      srts_pkg::S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = srts_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = srts_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/srts_dpath.sv @@
`timescale 1ns / 1ps

`include "sorted_record_table_search_macros.svh"

module srts_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  srts_pkg::srts_cmd_t                  cmd_i,
  output srts_pkg::srts_sts_t                  sts_o,
  input  logic [srts_pkg::DATE_W-1:0]          record_date_i,
  input  logic [srts_pkg::WORD_W-1:0]          temperature_bits_i,
  input  logic [srts_pkg::WORD_W-1:0]          phosphate_bits_i,
  input  logic [srts_pkg::WORD_W-1:0]          silicate_bits_i,
  input  logic [srts_pkg::WORD_W-1:0]          nitrite_bits_i,
  input  logic [srts_pkg::WORD_W-1:0]          nitrate_bits_i,
  input  logic [srts_pkg::WORD_W-1:0]          salinity_bits_i,
  input  logic [srts_pkg::WORD_W-1:0]          oxygen_bits_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [1:0]                           status_o,
  output logic [srts_pkg::POS_W-1:0]           position_o,
  output logic [srts_pkg::WORD_W-1:0]          temperature_out_o,
  output logic [srts_pkg::WORD_W-1:0]          phosphate_out_o,
  output logic [srts_pkg::WORD_W-1:0]          silicate_out_o,
  output logic [srts_pkg::WORD_W-1:0]          nitrite_out_o,
  output logic [srts_pkg::WORD_W-1:0]          nitrate_out_o,
  output logic [srts_pkg::WORD_W-1:0]          salinity_out_o,
  output logic [srts_pkg::WORD_W-1:0]          oxygen_out_o
);

  srts_pkg::srts_rec_t mem_q [srts_pkg::CAPACITY];

  srts_pkg::srts_rec_t                rec_q;
  srts_pkg::srts_rec_t                rdata_q;
  srts_pkg::srts_rec_t                wdata;
  srts_pkg::srts_rec_t                out_rec_q;
  srts_pkg::srts_status_e             res_status_q;
  srts_pkg::srts_status_e             out_status_q;
  logic [srts_pkg::CNT_W-1:0]         count_q;
  logic [srts_pkg::CNT_W-1:0]         lo_q;
  logic [srts_pkg::CNT_W-1:0]         hi_q;
  logic [srts_pkg::CNT_W-1:0]         mid;
  logic [srts_pkg::ADDR_W-1:0]        j_q;
  logic [srts_pkg::ADDR_W-1:0]        m_q;
  logic [srts_pkg::ADDR_W-1:0]        rd_addr;
  logic [srts_pkg::POS_W-1:0]         out_pos_q;
  logic [srts_pkg::POS_W-1:0]         pos_d;
  logic                               out_valid_q;
  logic                               out_free;

  assign mid = lo_q + ((hi_q - lo_q - srts_pkg::CNT_W'(1)) >> 1);

  always_comb begin
    case (cmd_i.rd_sel)
      srts_pkg::RD_COUNT_M1: rd_addr = srts_pkg::ADDR_W'(count_q - srts_pkg::CNT_W'(1));
      srts_pkg::RD_J_M2:     rd_addr = j_q - srts_pkg::ADDR_W'(2);
      srts_pkg::RD_MID:      rd_addr = mid[srts_pkg::ADDR_W-1:0];
      default:               rd_addr = '0;
    endcase
  end

  assign wdata = cmd_i.shift_we ? rdata_q : rec_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_we || cmd_i.place_we) begin
      mem_q[j_q] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rec_q.date        <= record_date_i;
      rec_q.temperature <= temperature_bits_i;
      rec_q.phosphate   <= phosphate_bits_i;
      rec_q.silicate    <= silicate_bits_i;
      rec_q.nitrite     <= nitrite_bits_i;
      rec_q.nitrate     <= nitrate_bits_i;
      rec_q.salinity    <= salinity_bits_i;
      rec_q.oxygen      <= oxygen_bits_i;
    end
    if (cmd_i.j_init) begin
      j_q <= count_q[srts_pkg::ADDR_W-1:0];
    end else if (cmd_i.j_dec) begin
      j_q <= j_q - srts_pkg::ADDR_W'(1);
    end
    if (cmd_i.lk_init) begin
      lo_q <= '0;
      hi_q <= count_q;
    end else if (cmd_i.lo_up) begin
      lo_q <= srts_pkg::CNT_W'(m_q) + srts_pkg::CNT_W'(1);
    end else if (cmd_i.hi_dn) begin
      hi_q <= srts_pkg::CNT_W'(m_q);
    end
    if (cmd_i.m_load) begin
      m_q <= mid[srts_pkg::ADDR_W-1:0];
    end
    if (cmd_i.status_we) begin
      res_status_q <= cmd_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.place_we) begin
        count_q <= count_q + srts_pkg::CNT_W'(1);
      end
      out_valid_q <= cmd_i.out_load | (out_valid_q & out_stall_i);
    end
  end

  always_comb begin
    case (res_status_q)
      srts_pkg::RES_INSERTED: pos_d = srts_pkg::POS_W'(j_q);
      srts_pkg::RES_FOUND:    pos_d = srts_pkg::POS_W'(m_q);
      default:                pos_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_pos_q    <= pos_d;
      out_rec_q    <= (res_status_q == srts_pkg::RES_FOUND) ? rdata_q : '0;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.count_full  = (count_q == srts_pkg::CNT_W'(srts_pkg::CAPACITY));
  assign sts_o.count_zero  = (count_q == '0);
  assign sts_o.j_one       = (j_q == srts_pkg::ADDR_W'(1));
  assign sts_o.rd_gt       = (rdata_q.date > rec_q.date);
  assign sts_o.rd_eq       = (rdata_q.date == rec_q.date);
  assign sts_o.range_empty = (lo_q >= hi_q);
  assign sts_o.out_free    = out_free;

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign position_o        = out_pos_q;
  assign temperature_out_o = out_rec_q.temperature;
  assign phosphate_out_o   = out_rec_q.phosphate;
  assign silicate_out_o    = out_rec_q.silicate;
  assign nitrite_out_o     = out_rec_q.nitrite;
  assign nitrate_out_o     = out_rec_q.nitrate;
  assign salinity_out_o    = out_rec_q.salinity;
  assign oxygen_out_o      = out_rec_q.oxygen;

  `SRTS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= srts_pkg::CNT_W'(srts_pkg::CAPACITY))
  `SRTS_ASSERT_NOW(a_place_not_full, cmd_i.place_we, !sts_o.count_full)
  `SRTS_ASSERT_NEXT(a_count_step, cmd_i.place_we,
                    count_q == $past(count_q) + srts_pkg::CNT_W'(1))
  `SRTS_ASSERT_NOW(a_load_free, cmd_i.out_load, out_free)

endmodule
